// ===== design/dime_pkg.sv =====
// Shared types, codes and sizes of the disk image extent map.
package dime_pkg;

   localparam int MAX_SECTIONS = 1024;
   localparam int ADDR_W = $clog2(MAX_SECTIONS);
   localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
   localparam int RESULT_CAP = 34;
   localparam int NUM_W = $clog2(RESULT_CAP);
   localparam logic [14:0] MAX_READ_BYTES = 15'd16384;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [31:0] METHOD_TERMINATOR = 32'hFFFF_FFFF;
   localparam logic [31:0] METHOD_COMMENT = 32'h7FFF_FFFE;
   localparam logic [31:0] METHOD_RAW = 32'd1;
   localparam logic [31:0] METHOD_ZERO = 32'd2;
   localparam logic [31:0] METHOD_PACKED_LO = 32'h8000_0004;
   localparam logic [31:0] METHOD_PACKED_HI = 32'h8000_0007;

   typedef enum logic [3:0] {
      RS_CHUNK = 4'd0,
      RS_EMPTY = 4'd1,
      RS_STORED = 4'd2,
      RS_FILTERED = 4'd3,
      RS_FULL = 4'd4,
      RS_CLEARED = 4'd5,
      RS_NOT_FOUND = 4'd6,
      RS_PAST_END = 4'd7,
      RS_GAP = 4'd8,
      RS_BAD_METHOD = 4'd9
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_COPY = 2'd1,
      ACT_ZERO = 2'd2,
      ACT_UNPACK = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRCH_ADDR,
      ST_SRCH_CMP,
      ST_WALK_ADDR,
      ST_WALK_CMP,
      ST_WALK_EMIT
   } state_type;

   typedef struct packed {
      logic [31:0] method;
      logic [48:0] disk_sector;
      logic [47:0] sector_total;
      logic [56:0] image_offset;
      logic [31:0] image_length;
   } sect_type;

   typedef struct packed {
      status_type status;
      action_type action;
      logic [31:0] method_code;
      logic [56:0] source_offset;
      logic [31:0] source_length;
      logic [56:0] section_size;
      logic [56:0] offset_in_section;
      logic [14:0] dest_offset;
      logic [14:0] chunk_length;
      logic last;
   } rsp_type;

endpackage

// ===== design/dime_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read.
module dime_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== design/dime_engine.sv =====
// Command sequencer: table load, binary search and chunk walk over the section RAM.
module dime_engine (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic raw_mode,
   input  logic [1:0] req_command,
   input  logic [31:0] req_entry_method,
   input  logic [47:0] req_entry_first_sector,
   input  logic [47:0] req_entry_sector_total,
   input  logic [55:0] req_entry_image_offset,
   input  logic [31:0] req_entry_image_length,
   input  logic [47:0] req_part_first_sector,
   input  logic [55:0] req_part_image_offset,
   input  logic [57:0] req_read_offset,
   input  logic [14:0] req_read_length,
   output logic busy,
   output logic emit_valid,
   output dime_pkg::rsp_type emit,
   output logic ram_wr_en,
   output logic [dime_pkg::ADDR_W-1:0] ram_wr_addr,
   output dime_pkg::sect_type ram_wr_data,
   output logic ram_rd_en,
   output logic [dime_pkg::ADDR_W-1:0] ram_rd_addr,
   input  dime_pkg::sect_type ram_rd_data
);

   dime_pkg::state_type state_ff, state_in;
   logic [dime_pkg::CNT_W-1:0] count_ff, count_in;
   logic [dime_pkg::CNT_W-1:0] lo_ff, lo_in, hix_ff, hix_in, idx_ff, idx_in;
   logic [dime_pkg::NUM_W-1:0] num_ff, num_in;
   logic [14:0] done_ff, done_in, len_ff, len_in;
   logic [58:0] offs_ff, offs_in;
   logic [56:0] rd_ff, rd_in, slen_ff, slen_in;

   logic [dime_pkg::CNT_W:0] mid_sum;
   logic [dime_pkg::CNT_W-1:0] mid;
   logic [57:0] start_w;
   logic [56:0] slen_w;
   logic [59:0] diff;
   logic below, in_sect;
   logic [56:0] rem;
   logic [14:0] sz;
   logic [14:0] clip_len;
   logic filtered;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hix_ff} - {{dime_pkg::CNT_W{1'b0}}, 1'b1};
   assign mid = mid_sum[dime_pkg::CNT_W:1];
   assign start_w = {ram_rd_data.disk_sector, 9'd0};
   assign slen_w = {ram_rd_data.sector_total, 9'd0};
   assign diff = {1'b0, offs_ff} - {2'b00, start_w};
   assign below = diff[59];
   assign in_sect = !below && (diff[58:0] < {2'b00, slen_w});
   assign rem = slen_ff - rd_ff;
   assign sz = (rem < {42'd0, len_ff}) ? rem[14:0] : len_ff;
   assign clip_len = (req_read_length > dime_pkg::MAX_READ_BYTES) ?
                     dime_pkg::MAX_READ_BYTES : req_read_length;
   assign filtered = (req_entry_method == dime_pkg::METHOD_TERMINATOR) ||
                     (req_entry_method == dime_pkg::METHOD_COMMENT) ||
                     (req_entry_sector_total == 48'd0);

   assign busy = (state_ff != dime_pkg::ST_IDLE);

   assign ram_wr_addr = count_ff[dime_pkg::ADDR_W-1:0];
   assign ram_wr_data.method = req_entry_method;
   assign ram_wr_data.disk_sector = {1'b0, req_entry_first_sector} +
                                    {1'b0, req_part_first_sector};
   assign ram_wr_data.sector_total = req_entry_sector_total;
   assign ram_wr_data.image_offset = {1'b0, req_entry_image_offset} +
                                     {1'b0, req_part_image_offset};
   assign ram_wr_data.image_length = req_entry_image_length;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lo_in = lo_ff;
      hix_in = hix_ff;
      idx_in = idx_ff;
      num_in = num_ff;
      done_in = done_ff;
      len_in = len_ff;
      offs_in = offs_ff;
      rd_in = rd_ff;
      slen_in = slen_ff;
      emit_valid = 1'b0;
      emit = '0;
      emit.last = 1'b1;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      ram_rd_addr = mid[dime_pkg::ADDR_W-1:0];
      case (state_ff)
         dime_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  dime_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     emit_valid = 1'b1;
                     emit.status = dime_pkg::RS_CLEARED;
                  end
                  dime_pkg::CMD_LOAD: begin
                     emit_valid = 1'b1;
                     if (filtered) begin
                        emit.status = dime_pkg::RS_FILTERED;
                     end else if (count_ff >= dime_pkg::CNT_W'(dime_pkg::MAX_SECTIONS)) begin
                        emit.status = dime_pkg::RS_FULL;
                     end else begin
                        ram_wr_en = 1'b1;
                        count_in = count_ff + 1'b1;
                        emit.status = dime_pkg::RS_STORED;
                     end
                  end
                  dime_pkg::CMD_READ: begin
                     if (raw_mode) begin
                        emit_valid = 1'b1;
                        if (clip_len == 15'd0) begin
                           emit.status = dime_pkg::RS_EMPTY;
                        end else begin
                           emit.status = dime_pkg::RS_CHUNK;
                           emit.action = dime_pkg::ACT_COPY;
                           emit.source_offset = req_read_offset[56:0];
                           emit.source_length = {17'd0, clip_len};
                           emit.chunk_length = clip_len;
                        end
                     end else begin
                        offs_in = {1'b0, req_read_offset};
                        len_in = clip_len;
                        lo_in = '0;
                        hix_in = count_ff;
                        done_in = '0;
                        num_in = '0;
                        state_in = dime_pkg::ST_SRCH_ADDR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         dime_pkg::ST_SRCH_ADDR: begin
            if (lo_ff >= hix_ff) begin
               emit_valid = 1'b1;
               emit.status = dime_pkg::RS_NOT_FOUND;
               state_in = dime_pkg::ST_IDLE;
            end else begin
               ram_rd_en = 1'b1;
               state_in = dime_pkg::ST_SRCH_CMP;
            end
         end
         dime_pkg::ST_SRCH_CMP: begin
            if (in_sect) begin
               idx_in = mid;
               if (len_ff == 15'd0) begin
                  emit_valid = 1'b1;
                  emit.status = dime_pkg::RS_EMPTY;
                  state_in = dime_pkg::ST_IDLE;
               end else begin
                  state_in = dime_pkg::ST_WALK_ADDR;
               end
            end else begin
               if (below) begin
                  hix_in = mid;
               end else begin
                  lo_in = mid + 1'b1;
               end
               state_in = dime_pkg::ST_SRCH_ADDR;
            end
         end
         dime_pkg::ST_WALK_ADDR: begin
            ram_rd_addr = idx_ff[dime_pkg::ADDR_W-1:0];
            if (idx_ff >= count_ff ||
                num_ff >= dime_pkg::NUM_W'(dime_pkg::RESULT_CAP - 1)) begin
               emit_valid = 1'b1;
               emit.status = dime_pkg::RS_PAST_END;
               emit.dest_offset = done_ff;
               state_in = dime_pkg::ST_IDLE;
            end else begin
               ram_rd_en = 1'b1;
               state_in = dime_pkg::ST_WALK_CMP;
            end
         end
         dime_pkg::ST_WALK_CMP: begin
            if (!in_sect) begin
               emit_valid = 1'b1;
               emit.status = dime_pkg::RS_GAP;
               emit.dest_offset = done_ff;
               state_in = dime_pkg::ST_IDLE;
            end else begin
               rd_in = diff[56:0];
               slen_in = slen_w;
               state_in = dime_pkg::ST_WALK_EMIT;
            end
         end
         dime_pkg::ST_WALK_EMIT: begin
            emit_valid = 1'b1;
            emit.method_code = ram_rd_data.method;
            emit.dest_offset = done_ff;
            emit.status = dime_pkg::RS_CHUNK;
            emit.section_size = slen_ff;
            emit.offset_in_section = rd_ff;
            emit.chunk_length = sz;
            emit.source_length = {17'd0, sz};
            emit.last = (len_ff == sz);
            if (ram_rd_data.method == dime_pkg::METHOD_RAW) begin
               emit.action = dime_pkg::ACT_COPY;
               emit.source_offset = ram_rd_data.image_offset + rd_ff;
            end else if (ram_rd_data.method == dime_pkg::METHOD_ZERO) begin
               emit.action = dime_pkg::ACT_ZERO;
            end else if (ram_rd_data.method inside
                         {[dime_pkg::METHOD_PACKED_LO:dime_pkg::METHOD_PACKED_HI]}) begin
               emit.action = dime_pkg::ACT_UNPACK;
               emit.source_offset = ram_rd_data.image_offset;
               emit.source_length = ram_rd_data.image_length;
            end else begin
               emit = '0;
               emit.status = dime_pkg::RS_BAD_METHOD;
               emit.method_code = ram_rd_data.method;
               emit.dest_offset = done_ff;
               emit.last = 1'b1;
            end
            if (emit.status == dime_pkg::RS_BAD_METHOD || len_ff == sz) begin
               state_in = dime_pkg::ST_IDLE;
            end else begin
               state_in = dime_pkg::ST_WALK_ADDR;
            end
            done_in = done_ff + sz;
            offs_in = offs_ff + {44'd0, sz};
            len_in = len_ff - sz;
            idx_in = idx_ff + 1'b1;
            num_in = num_ff + 1'b1;
         end
         default: begin
            state_in = dime_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dime_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hix_ff <= hix_in;
      idx_ff <= idx_in;
      num_ff <= num_in;
      done_ff <= done_in;
      len_ff <= len_in;
      offs_ff <= offs_in;
      rd_ff <= rd_in;
      slen_ff <= slen_in;
   end

endmodule

// ===== design/disk_image_extent_map.sv =====
// Top level of the disk image extent map: mode register, section RAM, sequencer, result register.
// Clear, load and raw reads are taken while idle and give one result word; unknown commands give none.
// Table reads: binary search in address and compare states (about ten steps for 1024 sections),
//   then walk address, compare, emit per chunk word, each bounded by the single RAM read port.
// Result words are registered and appear in the cycle after they are formed; the receiver cannot stall them.
// Synchronous reset clears the section count, raw mode and the sequencer; RAM is not cleared.
module disk_image_extent_map (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_command,
   input  logic [31:0] req_entry_method,
   input  logic [47:0] req_entry_first_sector,
   input  logic [47:0] req_entry_sector_total,
   input  logic [55:0] req_entry_image_offset,
   input  logic [31:0] req_entry_image_length,
   input  logic [47:0] req_part_first_sector,
   input  logic [55:0] req_part_image_offset,
   input  logic [57:0] req_read_offset,
   input  logic [14:0] req_read_length,
   output logic rsp_strobe,
   output logic [3:0] rsp_status,
   output logic [1:0] rsp_action,
   output logic [31:0] rsp_method_code,
   output logic [56:0] rsp_source_offset,
   output logic [31:0] rsp_source_length,
   output logic [56:0] rsp_section_size,
   output logic [56:0] rsp_offset_in_section,
   output logic [14:0] rsp_dest_offset,
   output logic [14:0] rsp_chunk_length,
   output logic rsp_last,
   input  logic csr_write_enable,
   input  logic csr_write_data
);

   logic raw_mode_ff;
   logic strobe_ff;
   dime_pkg::rsp_type rsp_ff;
   logic emit_valid;
   dime_pkg::rsp_type emit;
   logic ram_wr_en, ram_rd_en;
   logic [dime_pkg::ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   dime_pkg::sect_type ram_wr_data, ram_rd_data;

   dime_ram #(
      .WIDTH($bits(dime_pkg::sect_type)),
      .DEPTH(dime_pkg::MAX_SECTIONS)
   ) u_ram (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en(ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   dime_engine u_engine (
      .clock(clock),
      .reset(reset),
      .accept(start && !busy),
      .raw_mode(raw_mode_ff),
      .req_command(req_command),
      .req_entry_method(req_entry_method),
      .req_entry_first_sector(req_entry_first_sector),
      .req_entry_sector_total(req_entry_sector_total),
      .req_entry_image_offset(req_entry_image_offset),
      .req_entry_image_length(req_entry_image_length),
      .req_part_first_sector(req_part_first_sector),
      .req_part_image_offset(req_part_image_offset),
      .req_read_offset(req_read_offset),
      .req_read_length(req_read_length),
      .busy(busy),
      .emit_valid(emit_valid),
      .emit(emit),
      .ram_wr_en(ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_en(ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            raw_mode_ff <= csr_write_data;
         end
         strobe_ff <= emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= emit;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_action = rsp_ff.action;
   assign rsp_method_code = rsp_ff.method_code;
   assign rsp_source_offset = rsp_ff.source_offset;
   assign rsp_source_length = rsp_ff.source_length;
   assign rsp_section_size = rsp_ff.section_size;
   assign rsp_offset_in_section = rsp_ff.offset_in_section;
   assign rsp_dest_offset = rsp_ff.dest_offset;
   assign rsp_chunk_length = rsp_ff.chunk_length;
   assign rsp_last = rsp_ff.last;

   a_end_word: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_strobe && rsp_last)
      else $error("sequencer finished without a final word");

   a_more_is_chunk: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> rsp_status == dime_pkg::RS_CHUNK)
      else $error("non-final word is not a chunk");

   a_chunk_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == dime_pkg::RS_CHUNK |-> rsp_chunk_length != 15'd0)
      else $error("empty chunk word");

   a_zero_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_action == dime_pkg::ACT_ZERO |-> rsp_source_offset == 57'd0)
      else $error("zero fill with a source offset");

endmodule
